// File: rtl/core/blended_color_gradient_macros.svh
// assertion macros shared by the gradient block
`ifndef BLENDED_COLOR_GRADIENT_MACROS_SVH
`define BLENDED_COLOR_GRADIENT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BCG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcg assertion failed");

// next-cycle implication, checked outside reset
`define BCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcg assertion failed");

`endif

// File: rtl/core/bcg_pkg.sv
// shared types and constants of the gradient block
package bcg_pkg;

    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 3;
    localparam int COLOR_W       = CHAN_W * NUM_CHAN;
    localparam int ALPHA_W       = 8;
    localparam int LINE_W        = 12;
    localparam int PROD_W        = CHAN_W + LINE_W;
    localparam int CFG_DATA_W    = COLOR_W;
    localparam int CFG_IDX_W     = 3;
    localparam int DEF_MAX_LINES = 4096;

    localparam logic [COLOR_W-1:0] ORIGIN_RST     = '0;
    localparam logic [COLOR_W-1:0] OVERLAY_RST    = '0;
    localparam logic [ALPHA_W-1:0] START_ALPHA_RST = '0;
    localparam logic [ALPHA_W-1:0] END_ALPHA_RST  = 8'hff;
    localparam logic [LINE_W-1:0]  LINE_COUNT_RST = 12'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN      = 3'd0,
        CFG_OVERLAY     = 3'd1,
        CFG_START_ALPHA = 3'd2,
        CFG_END_ALPHA   = 3'd3,
        CFG_LINE_COUNT  = 3'd4
    } cfg_idx_t;

    // one color channel on its way through the divider chain
    typedef struct packed {
        logic [LINE_W-1:0] rem;
        logic [CHAN_W-1:0] low;
        logic [CHAN_W-1:0] quo;
        logic [CHAN_W-1:0] base;
        logic              neg;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_CHAN-1:0] lane;
        logic                 ok;
    } div_item_t;

endpackage

// File: rtl/core/bcg_if.sv
// request and response channel interfaces
interface bcg_req_if
    import bcg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] line_index;

    modport source (output valid, output line_index, input ready);
    modport sink (input valid, input line_index, output ready);
endinterface

interface bcg_rsp_if
    import bcg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] line_color;
    logic               line_valid;

    modport source (output valid, output line_color, output line_valid, input ready);
    modport sink (input valid, input line_color, input line_valid, output ready);
endinterface

// File: rtl/core/bcg_blend.sv
// alpha blend of origin and overlay into start and end colors
module bcg_blend
    import bcg_pkg::*;
(
    input  logic               clk,
    input  logic [COLOR_W-1:0] origin_color,
    input  logic [COLOR_W-1:0] overlay_color,
    input  logic [ALPHA_W-1:0] start_alpha,
    input  logic [ALPHA_W-1:0] end_alpha,
    output logic [COLOR_W-1:0] start_color,
    output logic [COLOR_W-1:0] end_color
);

    localparam int                 MUL_W     = CHAN_W + ALPHA_W + 1;
    localparam logic [ALPHA_W:0]   ALPHA_ONE = 9'h100;

    logic [COLOR_W-1:0] start_reg;
    logic [COLOR_W-1:0] start_next;
    logic [COLOR_W-1:0] end_reg;
    logic [COLOR_W-1:0] end_next;

    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0]  o,
        input logic [CHAN_W-1:0]  b,
        input logic [ALPHA_W-1:0] a
    );
        logic [MUL_W-1:0] po;
        logic [MUL_W-1:0] pb;
        po = MUL_W'(o) * MUL_W'(ALPHA_ONE - {1'b0, a});
        pb = MUL_W'(b) * MUL_W'(a);
        return po[MUL_W-2 -: CHAN_W] + pb[MUL_W-2 -: CHAN_W];
    endfunction

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            start_next[c*CHAN_W +: CHAN_W] = blend_chan(origin_color[c*CHAN_W +: CHAN_W],
                overlay_color[c*CHAN_W +: CHAN_W], start_alpha);
            end_next[c*CHAN_W +: CHAN_W] = blend_chan(origin_color[c*CHAN_W +: CHAN_W],
                overlay_color[c*CHAN_W +: CHAN_W], end_alpha);
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign start_color = start_reg;
    assign end_color   = end_reg;

endmodule

// File: rtl/core/bcg_div_cell.sv
// one restoring division step for all three channels
module bcg_div_cell
    import bcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LINE_W-1:0] divisor,
    input  logic              in_valid,
    output logic              in_ready,
    input  div_item_t         in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output div_item_t         out_item
);

    logic      valid_reg;
    logic      valid_next;
    div_item_t item_reg;
    div_item_t item_next;
    logic      rem_ok;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_valid;

    always_comb
    begin
        logic [LINE_W:0] trial;
        item_next = in_item;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            trial = {in_item.lane[c].rem, in_item.lane[c].low[CHAN_W-1]};
            if (trial >= {1'b0, divisor})
            begin
                item_next.lane[c].rem = LINE_W'(trial - {1'b0, divisor});
                item_next.lane[c].quo = {in_item.lane[c].quo[CHAN_W-2:0], 1'b1};
            end
            else
            begin
                item_next.lane[c].rem = trial[LINE_W-1:0];
                item_next.lane[c].quo = {in_item.lane[c].quo[CHAN_W-2:0], 1'b0};
            end
            item_next.lane[c].low = {in_item.lane[c].low[CHAN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        rem_ok = 1'b1;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (item_reg.lane[c].rem >= divisor)
            begin
                rem_ok = 1'b0;
            end
        end
    end

`include "blended_color_gradient_macros.svh"

    `BCG_ASSERT_IMPL(a_rem_below_divisor, valid_reg && item_reg.ok, rem_ok)

endmodule

// File: rtl/core/blended_color_gradient.sv
// gradient line color generator, top level
//
// Requests arrive on req, one line_index per transfer; each request yields
// exactly one transfer on rsp carrying line_color and line_valid, in order.
// Configuration is written through cfg_we / cfg_index / cfg_data and must
// only change while no request is in flight.
// A request passes through one input register, one multiply stage (channel
// difference times line index), eight division cells that each settle one
// quotient bit against line_count, and the output register that adds the
// quotient to the start color, or subtracts it where the end color is lower.
// Throughput is one line per cycle while rsp is ready; each stage hands its item on.
// When rsp is stalled the chain fills up, bubbles close, and req.ready drops
// only once every stage holds an item.
// Reset clears all stage valids and loads the register defaults; start and
// end colors follow from the registers in the next cycle.
module blended_color_gradient
    import bcg_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bcg_req_if.sink              req,
    bcg_rsp_if.source            rsp
);

    logic [COLOR_W-1:0] origin_reg;
    logic [COLOR_W-1:0] overlay_reg;
    logic [ALPHA_W-1:0] start_alpha_reg;
    logic [ALPHA_W-1:0] end_alpha_reg;
    logic [LINE_W-1:0]  line_count_reg;
    logic [LINE_W-1:0]  n_eff;

    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;

    logic               s0_v_reg;
    logic [LINE_W-1:0]  s0_idx_reg;
    logic               s0_en;

    logic               s1_v_reg;
    div_item_t          s1_item_reg;
    div_item_t          s1_item_next;
    logic               s1_en;

    logic [CHAN_W:0]    cell_v;
    logic [CHAN_W:0]    cell_rdy;
    div_item_t          cell_item [0:CHAN_W];

    logic               out_v_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [COLOR_W-1:0] out_color_next;
    logic               out_lv_reg;
    logic               out_en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg      <= ORIGIN_RST;
            overlay_reg     <= OVERLAY_RST;
            start_alpha_reg <= START_ALPHA_RST;
            end_alpha_reg   <= END_ALPHA_RST;
            line_count_reg  <= LINE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN:      origin_reg      <= cfg_data[COLOR_W-1:0];
                CFG_OVERLAY:     overlay_reg     <= cfg_data[COLOR_W-1:0];
                CFG_START_ALPHA: start_alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_END_ALPHA:   end_alpha_reg   <= cfg_data[ALPHA_W-1:0];
                CFG_LINE_COUNT:  line_count_reg  <= cfg_data[LINE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(line_count_reg) >= MAX_LINES)
        begin
            n_eff = LINE_W'(MAX_LINES - 1);
        end
        else
        begin
            n_eff = line_count_reg;
        end
    end

    bcg_blend u_blend (
        .clk           (clk),
        .origin_color  (origin_reg),
        .overlay_color (overlay_reg),
        .start_alpha   (start_alpha_reg),
        .end_alpha     (end_alpha_reg),
        .start_color   (start_color),
        .end_color     (end_color)
    );

    // input register
    assign s0_en     = !s0_v_reg || s1_en;
    assign req.ready = s0_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (s0_en)
        begin
            s0_v_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_en && req.valid)
        begin
            s0_idx_reg <= req.line_index;
        end
    end

    // multiply stage: |end - start| * index
    assign s1_en = !s1_v_reg || cell_rdy[0];

    always_comb
    begin
        logic [CHAN_W-1:0] s;
        logic [CHAN_W-1:0] e;
        logic [CHAN_W-1:0] d;
        logic [PROD_W-1:0] prod;
        s1_item_next.ok = (n_eff != '0) && (s0_idx_reg <= n_eff);
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            s    = start_color[c*CHAN_W +: CHAN_W];
            e    = end_color[c*CHAN_W +: CHAN_W];
            d    = (e < s) ? (s - e) : (e - s);
            prod = PROD_W'(d) * PROD_W'(s0_idx_reg);
            s1_item_next.lane[c].rem  = prod[PROD_W-1:CHAN_W];
            s1_item_next.lane[c].low  = prod[CHAN_W-1:0];
            s1_item_next.lane[c].quo  = '0;
            s1_item_next.lane[c].base = s;
            s1_item_next.lane[c].neg  = (e < s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && s0_v_reg)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    // division chain, one quotient bit per cell
    assign cell_v[0]      = s1_v_reg;
    assign cell_item[0]   = s1_item_reg;
    assign cell_rdy[CHAN_W] = out_en;

    for (genvar i = 0; i < CHAN_W; i++)
    begin : g_cell
        bcg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (n_eff),
            .in_valid  (cell_v[i]),
            .in_ready  (cell_rdy[i]),
            .in_item   (cell_item[i]),
            .out_valid (cell_v[i+1]),
            .out_ready (cell_rdy[i+1]),
            .out_item  (cell_item[i+1])
        );
    end

    // output register
    assign out_en = !out_v_reg || rsp.ready;

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (!cell_item[CHAN_W].ok)
            begin
                out_color_next[c*CHAN_W +: CHAN_W] = '0;
            end
            else if (cell_item[CHAN_W].lane[c].neg)
            begin
                out_color_next[c*CHAN_W +: CHAN_W] =
                    cell_item[CHAN_W].lane[c].base - cell_item[CHAN_W].lane[c].quo;
            end
            else
            begin
                out_color_next[c*CHAN_W +: CHAN_W] =
                    cell_item[CHAN_W].lane[c].base + cell_item[CHAN_W].lane[c].quo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_v_reg <= cell_v[CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && cell_v[CHAN_W])
        begin
            out_color_reg <= out_color_next;
            out_lv_reg    <= cell_item[CHAN_W].ok;
        end
    end

    assign rsp.valid      = out_v_reg;
    assign rsp.line_color = out_color_reg;
    assign rsp.line_valid = out_lv_reg;

`include "blended_color_gradient_macros.svh"

    `BCG_ASSERT_IMPL(a_empty_out_ready, !out_v_reg, req.ready)
    `BCG_ASSERT_IMPL(a_invalid_black, out_v_reg && !out_lv_reg, out_color_reg == '0)
    `BCG_ASSERT_NEXT(a_accept_loads, req.valid && req.ready, s0_v_reg)

endmodule

// File: tb/tb_blended_color_gradient.sv
// self-checking testbench of the gradient line color generator
module tb_blended_color_gradient;
    import bcg_pkg::*;

    localparam int MAX_LINES      = DEF_MAX_LINES;
    localparam int ALPHA_ONE      = 256;
    localparam int CFG_SETTLE     = 12;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int BATCHES        = 5;
    localparam int BATCH_LINES    = 115;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               valid;
    } line_result_t;

    typedef struct {
        logic [COLOR_W-1:0] origin;
        logic [COLOR_W-1:0] overlay;
        logic [ALPHA_W-1:0] start_alpha;
        logic [ALPHA_W-1:0] end_alpha;
        logic [LINE_W-1:0]  lines;
    } gradient_regs_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bcg_req_if req_ch ();
    bcg_rsp_if rsp_ch ();

    gradient_regs_t regs;
    line_result_t   expected_lines[$];
    line_result_t   want;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int lines_requested;
    int lines_checked;
    int lines_in_range;
    int settings_applied;

    blended_color_gradient i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int mix_chan(input int o, input int b, input int a);
        return (o * (ALPHA_ONE - a)) / ALPHA_ONE + (b * a) / ALPHA_ONE;
    endfunction

    function automatic line_result_t predict_line(input logic [LINE_W-1:0] idx);
        line_result_t res;
        int n;
        int k;
        int ch;
        int o;
        int b;
        int s;
        int e;
        res = '0;
        n = int'(regs.lines);
        k = int'(idx);
        if (n >= MAX_LINES)
        begin
            n = MAX_LINES - 1;
        end
        if (n == 0 || k > n)
        begin
            return res;
        end
        for (ch = 0; ch < NUM_CHAN; ch++)
        begin
            o = int'(regs.origin[ch*CHAN_W +: CHAN_W]);
            b = int'(regs.overlay[ch*CHAN_W +: CHAN_W]);
            s = mix_chan(o, b, int'(regs.start_alpha));
            e = mix_chan(o, b, int'(regs.end_alpha));
            // step toward the end color, truncating toward zero
            if (e >= s)
            begin
                res.color[ch*CHAN_W +: CHAN_W] = CHAN_W'(s + ((e - s) * k) / n);
            end
            else
            begin
                res.color[ch*CHAN_W +: CHAN_W] = CHAN_W'(s - ((s - e) * k) / n);
            end
        end
        res.valid = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("error at %0t: %s got %h, wanted %h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_lines.size() == 0)
            begin
                report_mismatch("response with no request", 32'(rsp_ch.line_color), '0);
            end
            else
            begin
                want = expected_lines.pop_front();
                lines_checked++;
                if (want.valid)
                begin
                    lines_in_range++;
                end
                if (rsp_ch.line_color !== want.color)
                begin
                    report_mismatch("line_color", 32'(rsp_ch.line_color), 32'(want.color));
                end
                if (rsp_ch.line_valid !== want.valid)
                begin
                    report_mismatch("line_valid", 32'(rsp_ch.line_valid), 32'(want.valid));
                end
            end
        end
    end

    // response ready, with random stalls and long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog: too long without any transfer
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_line(input logic [LINE_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.line_index <= idx;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        expected_lines = {expected_lines, predict_line(idx)};
        lines_requested++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_lines.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_ORIGIN:      regs.origin = data;
            CFG_OVERLAY:     regs.overlay = data;
            CFG_START_ALPHA: regs.start_alpha = data[ALPHA_W-1:0];
            CFG_END_ALPHA:   regs.end_alpha = data[ALPHA_W-1:0];
            CFG_LINE_COUNT:  regs.lines = data[LINE_W-1:0];
            default:         ;
        endcase
    endtask

    // all five registers plus a write to an unused index, only while idle
    task automatic load_regs(input logic [CFG_DATA_W-1:0] origin,
                             input logic [CFG_DATA_W-1:0] overlay,
                             input logic [CFG_DATA_W-1:0] start_alpha,
                             input logic [CFG_DATA_W-1:0] end_alpha,
                             input logic [CFG_DATA_W-1:0] lines);
        wait_drained();
        write_reg(CFG_ORIGIN, origin);
        write_reg(CFG_OVERLAY, overlay);
        write_reg(CFG_START_ALPHA, start_alpha);
        write_reg(CFG_END_ALPHA, end_alpha);
        write_reg(CFG_LINE_COUNT, lines);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                  CFG_DATA_W'($urandom()));
        cfg_we <= 1'b0;
        repeat (CFG_SETTLE) @(posedge clk);
        settings_applied++;
    endtask

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return ALPHA_W'($urandom());
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom());
        endcase
    endfunction

    function automatic logic [LINE_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10 || regs.lines == 0)
        begin
            return LINE_W'($urandom_range((1 << LINE_W) - 1));
        end
        if (roll < 16)
        begin
            return LINE_W'(32'(regs.lines) + $urandom_range(1));
        end
        return LINE_W'($urandom_range(regs.lines));
    endfunction

    task automatic load_random_regs();
        logic [CFG_DATA_W-1:0] junk;
        logic [LINE_W-1:0]     lc;
        junk = CFG_DATA_W'($urandom());
        case ($urandom_range(9))
            0:       lc = '0;
            1:       lc = 12'd1;
            2:       lc = '1;
            3:       lc = 12'd2;
            4, 5, 6: lc = LINE_W'($urandom_range(64, 3));
            default: lc = LINE_W'($urandom());
        endcase
        load_regs(pick_color(), pick_color(),
                  {junk[CFG_DATA_W-1:ALPHA_W], pick_alpha()},
                  {junk[CFG_DATA_W-1:ALPHA_W], pick_alpha()},
                  {junk[CFG_DATA_W-1:LINE_W], lc});
    endtask

    task automatic test_reset_defaults();
        send_line(12'd0);
        send_line(12'd1);
        send_line(12'd2);
        send_line('1);
    endtask

    task automatic test_directed_extremes();
        // falling gradient over the longest count, junk above the alpha and count bits
        load_regs('1, '0, 24'hA5C300, 24'h5A3CFF, 24'hFFFFFF);
        send_line(12'd0);
        send_line(12'd1);
        send_line(12'd2048);
        send_line(12'd4094);
        send_line('1);
        // mixed rising and falling channels, short count
        load_regs(24'h00FF80, 24'hFF0080, 24'h000080, 24'h0000FF, 24'h000003);
        send_line(12'd0);
        send_line(12'd1);
        send_line(12'd2);
        send_line(12'd3);
        send_line(12'd4);
        // disabled
        load_regs(24'h123456, 24'hFEDCBA, 24'h000010, 24'h0000F0, 24'hABC000);
        send_line(12'd0);
        send_line(12'd5);
        send_line('1);
        // single step, end alpha below start alpha
        load_regs('1, 24'h808080, '1, '0, 24'h000001);
        send_line(12'd0);
        send_line(12'd1);
        send_line(12'd2);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int b;
        int i;
        wait_drained();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (b = 0; b < BATCHES; b++)
        begin
            load_random_regs();
            for (i = 0; i < BATCH_LINES; i++)
            begin
                send_line(pick_index());
            end
        end
    endtask

    task automatic test_backpressure();
        int i;
        load_regs(pick_color(), pick_color(), CFG_DATA_W'(pick_alpha()),
                  CFG_DATA_W'(pick_alpha()), 24'd100);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 60; i++)
        begin
            send_line(pick_index());
        end
        // sender pauses until every result is back
        wait_drained();
        for (i = 0; i < 40; i++)
        begin
            send_line(pick_index());
        end
    endtask

    initial
    begin
        req_ch.valid      <= 1'b0;
        req_ch.line_index <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_ORIGIN;
        cfg_data          <= '0;
        regs.origin       = ORIGIN_RST;
        regs.overlay      = OVERLAY_RST;
        regs.start_alpha  = START_ALPHA_RST;
        regs.end_alpha    = END_ALPHA_RST;
        regs.lines        = LINE_COUNT_RST;
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        hold_left         = 0;
        mismatches        = 0;
        lines_requested   = 0;
        lines_checked     = 0;
        lines_in_range    = 0;
        settings_applied  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (CFG_SETTLE) @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_backpressure();
        test_random_traffic(26, 56);
        test_random_traffic(56, 26);
        test_random_traffic(0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d line requests over %0d register settings", lines_requested,
                 settings_applied);
        $display("checked %0d results, %0d of them inside the gradient", lines_checked,
                 lines_in_range);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
